// File: src/tipp_pkg.sv
// shared types and constants for the text image pixel parser
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package tipp_pkg;

    localparam int DIM_BITS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int BYTE_W   = 8;
    localparam int ORIGIN_W = 16;
    localparam int COORD_W  = 17;
    localparam int COLOR_W  = 8;
    localparam int KIND_W   = 3;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;

    localparam logic [KIND_W-1:0] K_PIXEL    = 3'd0;
    localparam logic [KIND_W-1:0] K_SUCCESS  = 3'd1;
    localparam logic [KIND_W-1:0] K_NOWIDTH  = 3'd2;
    localparam logic [KIND_W-1:0] K_NOHEIGHT = 3'd3;
    localparam logic [KIND_W-1:0] K_NORED    = 3'd4;
    localparam logic [KIND_W-1:0] K_NOGREEN  = 3'd5;
    localparam logic [KIND_W-1:0] K_NOBLUE   = 3'd6;
    localparam logic [KIND_W-1:0] K_OVERFLOW = 3'd7;

    // register index, taken from paddr[2]
    localparam logic REG_ORIGIN_X = 1'b0;
    localparam logic REG_ORIGIN_Y = 1'b1;

    // one classified byte as it waits in the queue
    typedef struct packed {
        logic              is_nul;
        logic              is_space;
        logic              is_nl;
        logic [BYTE_W-1:0] value;
    } t_item;

endpackage

`default_nettype wire

// File: src/tipp_fifo.sv
// short queue of classified bytes between front and back
// depends on tipp_pkg for the item type
`default_nettype none

module tipp_fifo #(
    parameter int DEPTH = tipp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  tipp_pkg::t_item       i_item,
    output logic                  o_full,
    input  wire                   i_pop,
    output tipp_pkg::t_item       o_item,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tipp_pkg::t_item    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_rd;
    logic [PTR_W-1:0]   r_wr;
    logic [CNT_W-1:0]   r_cnt;
    logic               push_ok;
    logic               pop_ok;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/tipp_front.sv
// input side: takes bytes and tags delimiters before queueing
// depends on tipp_pkg for character codes and the item type
`default_nettype none

module tipp_front (
    input  wire                          i_valid,
    input  wire [tipp_pkg::BYTE_W-1:0]   i_byte,
    output logic                         o_stall,
    input  wire                          i_full,
    output logic                         o_push,
    output tipp_pkg::t_item              o_item
);

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item.is_nul   = (i_byte == tipp_pkg::CH_NUL);
        o_item.is_space = (i_byte == tipp_pkg::CH_SPACE);
        o_item.is_nl    = (i_byte == tipp_pkg::CH_NL);
        o_item.value    = i_byte;
    end

endmodule

`default_nettype wire

// File: src/tipp_back.sv
// parse state machine: header, color fields, pixel placement and results
// depends on tipp_pkg for result codes and the item type
`default_nettype none

module tipp_back #(
    parameter int DIM_BITS = tipp_pkg::DIM_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire [tipp_pkg::ORIGIN_W-1:0]     i_origin_x,
    input  wire [tipp_pkg::ORIGIN_W-1:0]     i_origin_y,
    input  tipp_pkg::t_item                  i_item,
    input  wire                              i_empty,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [tipp_pkg::KIND_W-1:0]      o_kind,
    output logic [tipp_pkg::COORD_W-1:0]     o_x,
    output logic [tipp_pkg::COORD_W-1:0]     o_y,
    output logic [tipp_pkg::COLOR_W-1:0]     o_red,
    output logic [tipp_pkg::COLOR_W-1:0]     o_green,
    output logic [tipp_pkg::COLOR_W-1:0]     o_blue
);

    localparam int CW    = ((DIM_BITS > tipp_pkg::ORIGIN_W) ? DIM_BITS : tipp_pkg::ORIGIN_W) + 1;
    localparam int SUM_W = DIM_BITS + 5;
    localparam int CLW   = tipp_pkg::COLOR_W;

    typedef enum logic [2:0] {
        PH_WIDTH, PH_HEIGHT, PH_PSTART, PH_RED, PH_GREEN, PH_BLUE, PH_DRAIN, PH_LAST
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [DIM_BITS-1:0]    r_width, n_width;
    logic [DIM_BITS-1:0]    r_height, n_height;
    logic [CW-1:0]          r_cx, n_cx;
    logic [CW-1:0]          r_cy, n_cy;
    logic [CLW-1:0]         r_racc, n_racc;
    logic [CLW-1:0]         r_gacc, n_gacc;
    logic [CLW-1:0]         r_bacc, n_bacc;
    logic                   r_ovalid, n_ovalid;
    logic [tipp_pkg::KIND_W-1:0]  r_kind, n_kind;
    logic [tipp_pkg::COORD_W-1:0] r_x, n_x;
    logic [tipp_pkg::COORD_W-1:0] r_y, n_y;
    logic [CLW-1:0]         r_r, n_r;
    logic [CLW-1:0]         r_g, n_g;
    logic [CLW-1:0]         r_b, n_b;

    logic                   take;
    logic [DIM_BITS-1:0]    dim_acc;
    logic [SUM_W-1:0]       dim_sum;
    logic [SUM_W-1:0]       dim_diff;
    logic [DIM_BITS-1:0]    dim_new;
    logic [CLW-1:0]         col_acc;
    logic [CLW-1:0]         col_new;
    logic [CW-1:0]          org_x;
    logic [CW-1:0]          org_y;
    logic [CW-1:0]          xend;
    logic [CW-1:0]          yend;
    logic [CW-1:0]          cx_inc;
    logic [CW-1:0]          cy_inc;

    // an item is worked on when the result register is free or being drained
    assign take  = !i_empty && (!r_ovalid || !i_stall);
    assign o_pop = take;

    // shared decimal step for width and height, with saturation
    always_comb begin
        dim_acc  = (r_phase == PH_HEIGHT) ? r_height : r_width;
        dim_sum  = (SUM_W'(dim_acc) << 3) + (SUM_W'(dim_acc) << 1) + SUM_W'(i_item.value);
        dim_diff = dim_sum - SUM_W'(tipp_pkg::CH_ZERO);
        if (dim_sum < SUM_W'(tipp_pkg::CH_ZERO) || dim_diff[SUM_W-1:DIM_BITS] != '0) begin
            dim_new = '1;
        end else begin
            dim_new = dim_diff[DIM_BITS-1:0];
        end
    end

    // shared decimal step for the colors, wraps modulo 256
    always_comb begin
        unique case (r_phase)
            PH_GREEN: col_acc = r_gacc;
            PH_BLUE:  col_acc = r_bacc;
            default:  col_acc = r_racc;
        endcase
        col_new = {col_acc[CLW-4:0], 3'b000} + {col_acc[CLW-2:0], 1'b0}
                + i_item.value - tipp_pkg::CH_ZERO;
    end

    assign org_x  = CW'(i_origin_x);
    assign org_y  = CW'(i_origin_y);
    assign xend   = org_x + CW'(r_width);
    assign yend   = org_y + CW'(r_height);
    assign cx_inc = r_cx + 1'b1;
    assign cy_inc = r_cy + 1'b1;

    always_comb begin
        n_phase  = r_phase;
        n_width  = r_width;
        n_height = r_height;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_racc   = r_racc;
        n_gacc   = r_gacc;
        n_bacc   = r_bacc;
        n_ovalid = r_ovalid && i_stall;
        n_kind   = r_kind;
        n_x      = r_x;
        n_y      = r_y;
        n_r      = r_r;
        n_g      = r_g;
        n_b      = r_b;
        if (take) begin
            n_ovalid = 1'b0;
            n_x      = '0;
            n_y      = '0;
            n_r      = '0;
            n_g      = '0;
            n_b      = '0;
            unique case (r_phase)
                PH_WIDTH: begin
                    if (i_item.is_space) begin
                        n_phase = PH_HEIGHT;
                    end else if (i_item.is_nul) begin
                        n_phase  = PH_WIDTH;
                        n_width  = '0;
                        n_height = '0;
                        n_ovalid = 1'b1;
                        n_kind   = tipp_pkg::K_NOWIDTH;
                    end else begin
                        n_width = dim_new;
                    end
                end
                PH_HEIGHT: begin
                    if (i_item.is_nl) begin
                        n_cx    = org_x;
                        n_cy    = org_y;
                        n_racc  = '0;
                        n_gacc  = '0;
                        n_bacc  = '0;
                        n_phase = PH_PSTART;
                    end else if (i_item.is_nul) begin
                        n_phase  = PH_WIDTH;
                        n_width  = '0;
                        n_height = '0;
                        n_ovalid = 1'b1;
                        n_kind   = tipp_pkg::K_NOHEIGHT;
                    end else begin
                        n_height = dim_new;
                    end
                end
                PH_PSTART, PH_RED: begin
                    if (i_item.is_nul) begin
                        n_phase  = PH_WIDTH;
                        n_width  = '0;
                        n_height = '0;
                        n_ovalid = 1'b1;
                        n_kind   = (r_phase == PH_PSTART) ? tipp_pkg::K_SUCCESS
                                                          : tipp_pkg::K_NORED;
                    end else if (i_item.is_space) begin
                        n_phase = PH_GREEN;
                    end else begin
                        n_phase = PH_RED;
                        n_racc  = col_new;
                    end
                end
                PH_GREEN: begin
                    if (i_item.is_space) begin
                        n_phase = PH_BLUE;
                    end else if (i_item.is_nul) begin
                        n_phase  = PH_WIDTH;
                        n_width  = '0;
                        n_height = '0;
                        n_ovalid = 1'b1;
                        n_kind   = tipp_pkg::K_NOGREEN;
                    end else begin
                        n_gacc = col_new;
                    end
                end
                PH_BLUE: begin
                    if (i_item.is_nul) begin
                        n_phase  = PH_WIDTH;
                        n_width  = '0;
                        n_height = '0;
                        n_ovalid = 1'b1;
                        n_kind   = tipp_pkg::K_NOBLUE;
                    end else if (!i_item.is_nl) begin
                        n_bacc = col_new;
                    end else if (!(r_cx < xend && r_cy < yend)) begin
                        n_phase  = PH_DRAIN;
                        n_ovalid = 1'b1;
                        n_kind   = tipp_pkg::K_OVERFLOW;
                    end else begin
                        // place the pixel and step the cursor row by row
                        n_ovalid = 1'b1;
                        n_kind   = tipp_pkg::K_PIXEL;
                        n_x      = r_cx[tipp_pkg::COORD_W-1:0];
                        n_y      = r_cy[tipp_pkg::COORD_W-1:0];
                        n_r      = r_racc;
                        n_g      = r_gacc;
                        n_b      = r_bacc;
                        n_racc   = '0;
                        n_gacc   = '0;
                        n_bacc   = '0;
                        n_phase  = PH_PSTART;
                        if (cx_inc == xend) begin
                            n_cx = org_x;
                            n_cy = cy_inc;
                            if (cy_inc == yend) begin
                                n_phase = PH_LAST;
                            end
                        end else begin
                            n_cx = cx_inc;
                        end
                    end
                end
                PH_LAST: begin
                    n_ovalid = 1'b1;
                    n_kind   = tipp_pkg::K_SUCCESS;
                    if (i_item.is_nul) begin
                        n_phase  = PH_WIDTH;
                        n_width  = '0;
                        n_height = '0;
                    end else begin
                        n_phase = PH_DRAIN;
                    end
                end
                PH_DRAIN: begin
                    if (i_item.is_nul) begin
                        n_phase  = PH_WIDTH;
                        n_width  = '0;
                        n_height = '0;
                    end
                end
                default: begin
                    n_phase = PH_WIDTH;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WIDTH;
            r_width  <= '0;
            r_height <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_racc   <= '0;
            r_gacc   <= '0;
            r_bacc   <= '0;
            r_ovalid <= 1'b0;
            r_kind   <= tipp_pkg::K_PIXEL;
            r_x      <= '0;
            r_y      <= '0;
            r_r      <= '0;
            r_g      <= '0;
            r_b      <= '0;
        end else begin
            r_phase  <= n_phase;
            r_width  <= n_width;
            r_height <= n_height;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_racc   <= n_racc;
            r_gacc   <= n_gacc;
            r_bacc   <= n_bacc;
            r_ovalid <= n_ovalid;
            r_kind   <= n_kind;
            r_x      <= n_x;
            r_y      <= n_y;
            r_r      <= n_r;
            r_g      <= n_g;
            r_b      <= n_b;
        end
    end

    assign o_valid = r_ovalid;
    assign o_kind  = r_kind;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_red   = r_r;
    assign o_green = r_g;
    assign o_blue  = r_b;

endmodule

`default_nettype wire

// File: src/text_image_pixel_parser_top.sv
// top level of the text image pixel parser: register port, front, queue, back
// depends on tipp_pkg, tipp_front, tipp_fifo and tipp_back
`default_nettype none

//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+-------------------------------
//  in       | in        | i_in_valid / o_in_stall        | i_byte_value
//  out      | out       | o_out_valid / i_out_stall      | o_result_kind, o_pixel_x/y,
//           |           |                                | o_red, o_green, o_blue
//  config   | in        | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
//  one item per cycle sustained while a held result is not stalled; the back end does one decimal step per byte
//  an accepted item passes through the byte queue and then the result register before it shows on the out channel
//  o_in_stall rises only when the byte queue is full (QUEUE_DEPTH items)
//  i_out_stall holds the result register and, while it holds a result, pauses the back end; the queue keeps filling
//  synchronous active-low reset returns to width parsing with zero origin

module text_image_pixel_parser_top #(
    parameter int DIM_BITS    = tipp_pkg::DIM_BITS_DEF,
    parameter int QUEUE_DEPTH = tipp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // byte input
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire [tipp_pkg::BYTE_W-1:0]        i_byte_value,
    // result output
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [tipp_pkg::KIND_W-1:0]       o_result_kind,
    output logic [tipp_pkg::COORD_W-1:0]      o_pixel_x,
    output logic [tipp_pkg::COORD_W-1:0]      o_pixel_y,
    output logic [tipp_pkg::COLOR_W-1:0]      o_red,
    output logic [tipp_pkg::COLOR_W-1:0]      o_green,
    output logic [tipp_pkg::COLOR_W-1:0]      o_blue,
    // register port
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [tipp_pkg::PADDR_W-1:0]       paddr,
    input  wire [tipp_pkg::PDATA_W-1:0]       pwdata,
    output logic [tipp_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    logic [tipp_pkg::ORIGIN_W-1:0] r_origin_x;
    logic [tipp_pkg::ORIGIN_W-1:0] r_origin_y;
    logic                          reg_wr;
    logic                          reg_idx;

    tipp_pkg::t_item               front_item;
    tipp_pkg::t_item               queue_item;
    logic                          push;
    logic                          full;
    logic                          pop;
    logic                          empty;

    // register port: zero wait states, word index from address bit 2
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign reg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
        end else if (reg_wr) begin
            unique case (reg_idx)
                tipp_pkg::REG_ORIGIN_X: r_origin_x <= pwdata[tipp_pkg::ORIGIN_W-1:0];
                tipp_pkg::REG_ORIGIN_Y: r_origin_y <= pwdata[tipp_pkg::ORIGIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tipp_pkg::REG_ORIGIN_Y: prdata = tipp_pkg::PDATA_W'(r_origin_y);
            default:                prdata = tipp_pkg::PDATA_W'(r_origin_x);
        endcase
    end

    // front: classify each byte as it is accepted
    tipp_front u_front (
        .i_valid (i_in_valid),
        .i_byte  (i_byte_value),
        .o_stall (o_in_stall),
        .i_full  (full),
        .o_push  (push),
        .o_item  (front_item)
    );

    // queue decouples input acceptance from output stalls
    tipp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_empty (empty)
    );

    // back: parse state, pixel placement, registered result
    tipp_back #(
        .DIM_BITS (DIM_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_origin_x (r_origin_x),
        .i_origin_y (r_origin_y),
        .i_item     (queue_item),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_kind     (o_result_kind),
        .o_x        (o_pixel_x),
        .o_y        (o_pixel_y),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue)
    );

endmodule

`default_nettype wire

// File: dv/testbench.sv
// self-checking testbench for text_image_pixel_parser_top: byte items in, pixel/status items out
// depends on tipp_pkg and the block's rtl; predicts every output item and checks it field by field

module testbench;
    import tipp_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 7;
    // byte queue depth plus the queue and result registers plus margin: bytes with no output may still be inside
    localparam int SETTLE_CYCLES  = 12;
    localparam int IDLE_PCT       = 17;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 600;
    localparam int DIM_W          = DIM_BITS_DEF;
    localparam logic [DIM_W-1:0] DIM_MAX = '1;

    // parse phases of the predictor
    typedef enum logic [2:0] {
        ST_WIDTH,
        ST_HEIGHT,
        ST_PIX_START,
        ST_RED,
        ST_GREEN,
        ST_BLUE,
        ST_SKIP,
        ST_LAST
    } t_parse_state;

    // one output item as the block should present it
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_parser_out;

    // block ports, all inputs known from time zero
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic [BYTE_W-1:0]    i_byte_value = '0;
    logic                 i_out_stall  = 1'b0;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [PADDR_W-1:0]   paddr        = '0;
    logic [PDATA_W-1:0]   pwdata       = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [KIND_W-1:0]    o_result_kind;
    logic [COORD_W-1:0]   o_pixel_x;
    logic [COORD_W-1:0]   o_pixel_y;
    logic [COLOR_W-1:0]   o_red;
    logic [COLOR_W-1:0]   o_green;
    logic [COLOR_W-1:0]   o_blue;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // stall control for the output side
    logic quiet_out = 1'b0;   // forces i_out_stall low while draining
    logic calm      = 1'b0;   // stretch with no idling on either side

    // predictor state, reset values
    t_parse_state         parse_state = ST_WIDTH;
    logic [DIM_W-1:0]     img_w       = '0;
    logic [DIM_W-1:0]     img_h       = '0;
    logic [COORD_W-1:0]   cur_x       = '0;
    logic [COORD_W-1:0]   cur_y       = '0;
    logic [COLOR_W-1:0]   red_acc     = '0;
    logic [COLOR_W-1:0]   green_acc   = '0;
    logic [COLOR_W-1:0]   blue_acc    = '0;
    logic [ORIGIN_W-1:0]  origin_x    = '0;
    logic [ORIGIN_W-1:0]  origin_y    = '0;

    // output items still owed by the block, oldest first
    t_parser_out pending_outputs[$];

    int unsigned mismatches   = 0;
    int unsigned bytes_sent   = 0;
    int unsigned bytes_parsed = 0;   // bytes not swallowed by the skip phase
    int unsigned origin_writes = 0;
    int unsigned kind_count[8];
    int unsigned idle_cycles  = 0;

    text_image_pixel_parser_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_byte_value  (i_byte_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_kind (o_result_kind),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // decimal step for width/height: underflow or overflow pins at all ones
    function automatic logic [DIM_W-1:0] dim_step(input logic [DIM_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] ch);
        int unsigned t;
        t = acc * 10 + ch;
        if (t < CH_ZERO) begin
            return DIM_MAX;
        end
        t = t - CH_ZERO;
        return (t > DIM_MAX) ? DIM_MAX : t[DIM_W-1:0];
    endfunction

    // decimal step for a color: unchecked digit, wraps modulo 256
    function automatic logic [COLOR_W-1:0] color_step(input logic [COLOR_W-1:0] acc,
                                                       input logic [BYTE_W-1:0] ch);
        int unsigned t;
        t = acc * 10 + ch - CH_ZERO;
        return t[COLOR_W-1:0];
    endfunction

    task automatic start_new_image();
        parse_state = ST_WIDTH;
        img_w = '0;
        img_h = '0;
    endtask

    // advance the predictor by one accepted byte and queue the output it causes
    task automatic decode_byte(input logic [BYTE_W-1:0] ch);
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        t_parser_out        res;
        bit                 emit;
        res   = '0;
        emit  = 1'b0;
        // bounds always follow the live origin registers
        x_end = COORD_W'(origin_x) + COORD_W'(img_w);
        y_end = COORD_W'(origin_y) + COORD_W'(img_h);
        case (parse_state)
            ST_WIDTH: begin
                if (ch == CH_SPACE) begin
                    parse_state = ST_HEIGHT;
                end else if (ch == CH_NUL) begin
                    res.kind = K_NOWIDTH;
                    emit = 1'b1;
                    start_new_image();
                end else begin
                    img_w = dim_step(img_w, ch);
                end
            end
            ST_HEIGHT: begin
                if (ch == CH_NL) begin
                    // cursor latches the origin at the end of the header
                    cur_x = COORD_W'(origin_x);
                    cur_y = COORD_W'(origin_y);
                    red_acc = '0;
                    green_acc = '0;
                    blue_acc = '0;
                    parse_state = ST_PIX_START;
                end else if (ch == CH_NUL) begin
                    res.kind = K_NOHEIGHT;
                    emit = 1'b1;
                    start_new_image();
                end else begin
                    img_h = dim_step(img_h, ch);
                end
            end
            ST_PIX_START, ST_RED: begin
                // a zero right at a pixel start closes the image cleanly
                if (ch == CH_NUL) begin
                    res.kind = (parse_state == ST_PIX_START) ? K_SUCCESS : K_NORED;
                    emit = 1'b1;
                    start_new_image();
                end else if (ch == CH_SPACE) begin
                    parse_state = ST_GREEN;
                end else begin
                    red_acc = color_step(red_acc, ch);
                    parse_state = ST_RED;
                end
            end
            ST_GREEN: begin
                if (ch == CH_SPACE) begin
                    parse_state = ST_BLUE;
                end else if (ch == CH_NUL) begin
                    res.kind = K_NOGREEN;
                    emit = 1'b1;
                    start_new_image();
                end else begin
                    green_acc = color_step(green_acc, ch);
                end
            end
            ST_BLUE: begin
                if (ch == CH_NUL) begin
                    res.kind = K_NOBLUE;
                    emit = 1'b1;
                    start_new_image();
                end else if (ch != CH_NL) begin
                    blue_acc = color_step(blue_acc, ch);
                end else if (!(cur_x < x_end && cur_y < y_end)) begin
                    // triple lands outside the declared area
                    res.kind = K_OVERFLOW;
                    emit = 1'b1;
                    parse_state = ST_SKIP;
                end else begin
                    res.kind  = K_PIXEL;
                    res.x     = cur_x;
                    res.y     = cur_y;
                    res.red   = red_acc;
                    res.green = green_acc;
                    res.blue  = blue_acc;
                    emit = 1'b1;
                    cur_x = cur_x + 1'b1;
                    parse_state = ST_PIX_START;
                    if (cur_x == x_end) begin
                        cur_x = COORD_W'(origin_x);
                        cur_y = cur_y + 1'b1;
                        if (cur_y == y_end) begin
                            parse_state = ST_LAST;
                        end
                    end
                    red_acc = '0;
                    green_acc = '0;
                    blue_acc = '0;
                end
            end
            ST_LAST: begin
                // the byte after the last pixel reports success whatever it is
                res.kind = K_SUCCESS;
                emit = 1'b1;
                if (ch == CH_NUL) begin
                    start_new_image();
                end else begin
                    parse_state = ST_SKIP;
                end
            end
            default: begin
                // skip phase: ignore everything up to and including a zero
                if (ch == CH_NUL) begin
                    start_new_image();
                end
            end
        endcase
        if (emit) begin
            pending_outputs.push_back(res);
        end
    endtask

    // ------------------------------------------------------------------
    // output side: random stall, checking, watchdog
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        i_out_stall <= !quiet_out && !calm && ($urandom_range(99) < IDLE_PCT);
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // sample at the edge, before any of this step's nonblocking updates land
    always @(posedge i_clk) begin
        t_parser_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outputs.size() == 0) begin
                $error("output item with nothing expected: kind %0d", o_result_kind);
                mismatches++;
            end else begin
                want = pending_outputs.pop_front();
                kind_count[want.kind]++;
                check_field("result_kind", 32'(want.kind), 32'(o_result_kind));
                check_field("pixel_x", 32'(want.x), 32'(o_pixel_x));
                check_field("pixel_y", 32'(want.y), 32'(o_pixel_y));
                check_field("red", 32'(want.red), 32'(o_red));
                check_field("green", 32'(want.green), 32'(o_green));
                check_field("blue", 32'(want.blue), 32'(o_blue));
            end
        end
    end

    // give up when nothing moves on either channel or the register port for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without progress, %0d items owed",
                     idle_cycles, pending_outputs.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // input side and register port
    // ------------------------------------------------------------------

    // send one byte item; valid stays high afterwards unless the next call idles first
    task automatic push_byte(input logic [BYTE_W-1:0] ch);
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_byte_value <= ch;
        do @(posedge i_clk); while (o_in_stall);
        if (parse_state != ST_SKIP) begin
            bytes_parsed++;
        end
        bytes_sent++;
        decode_byte(ch);
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) begin
            push_byte(s[i]);
        end
    endtask

    task automatic send_num(input int unsigned v);
        send_text($sformatf("%0d", v));
    endtask

    // hold the sender until every owed item is out and the pipe has emptied
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        quiet_out  <= 1'b1;
        while (pending_outputs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        quiet_out <= 1'b0;
    endtask

    task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_ORIGIN_X) begin
            origin_x = value[ORIGIN_W-1:0];
        end else begin
            origin_y = value[ORIGIN_W-1:0];
        end
        origin_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic idx);
        logic [PDATA_W-1:0] want;
        want = (idx == REG_ORIGIN_X) ? PDATA_W'(origin_x) : PDATA_W'(origin_y);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field((idx == REG_ORIGIN_X) ? "origin_x" : "origin_y", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // origin moves only once the block has gone quiet
    task automatic set_origin(input logic [PDATA_W-1:0] x, input logic [PDATA_W-1:0] y);
        drain_outputs();
        write_reg(REG_ORIGIN_X, x);
        write_reg(REG_ORIGIN_Y, y);
    endtask

    function automatic logic [PDATA_W-1:0] pick_origin();
        case ($urandom_range(3))
            0: return '0;
            1: return 32'h0000_FFFF;
            2: return $urandom;   // upper bits set too, the register keeps 16
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    // any byte that is not a zero, space or newline: an unchecked digit
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(1, 255)); while (b == CH_NL || b == CH_SPACE);
        return b;
    endfunction

    task automatic send_color_field();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            send_num($urandom_range(0, 255));
        end else if (pick < 85) begin
            send_num($urandom_range(256, 99999));   // wraps
        end else if (pick < 95) begin
            repeat ($urandom_range(1, 3)) push_byte(plain_byte());
        end
        // else an empty field
    endtask

    task automatic send_pixel();
        send_color_field();
        push_byte(CH_SPACE);
        send_color_field();
        push_byte(CH_SPACE);
        send_color_field();
        push_byte(CH_NL);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_register_access();
        check_reg(REG_ORIGIN_X);
        check_reg(REG_ORIGIN_Y);
        set_origin(32'h0000_FFFF, 32'h0);
        check_reg(REG_ORIGIN_X);
        check_reg(REG_ORIGIN_Y);
        set_origin(32'hABCD_0000, 32'h5A5A_FFFF);
        check_reg(REG_ORIGIN_X);
        check_reg(REG_ORIGIN_Y);
        set_origin(32'h0, 32'h0);
    endtask

    // a zero inside each field, and a zero right at a pixel start
    task automatic test_missing_fields();
        push_byte(CH_NUL);
        send_text(" ");
        push_byte(CH_NUL);
        send_text(" \n");
        push_byte(CH_NUL);
        send_text(" \n7");
        push_byte(CH_NUL);
        send_text(" \n7 ");
        push_byte(CH_NUL);
        send_text(" \n7 8 9");
        push_byte(CH_NUL);
    endtask

    // full image at the far corner of the screen, colors at and past the extremes
    task automatic test_full_image();
        set_origin(32'h0000_FFFF, 32'h0000_FFFF);
        send_text("2 1\n255 0 9\n256 999 1\n");
        push_byte(CH_NUL);
        // last pixel followed by junk: success, then skip up to the zero
        set_origin(32'h0, 32'h0);
        send_text("1 1\n1 2 3\nxq");
        push_byte(CH_NUL);
    endtask

    // zero-sized area: the first triple overflows and the rest is skipped
    task automatic test_overflow();
        send_text(" \n  \nz");
        push_byte(CH_NUL);
    endtask

    // saturating dimensions and raw non-digit bytes counted as digits
    task automatic test_raw_digits();
        send_text("99999 ");
        push_byte(8'h01);
        push_byte(CH_NL);
        push_byte(8'hFF);
        push_byte(CH_SPACE);
        push_byte("a");
        push_byte(CH_SPACE);
        push_byte(8'h80);
        push_byte(CH_NL);
        push_byte(CH_NUL);
    endtask

    // origin moved mid-image: cursor keeps the old origin, bounds use the new one
    task automatic test_origin_change();
        set_origin(32'd5, 32'd3);
        send_text("2 2\n1 1 1\n");
        set_origin(32'd0, 32'd3);
        send_text("2 2 2\n9");
        push_byte(CH_NUL);
        set_origin(32'd0, 32'd0);
    endtask

    // mostly well-formed images with random content, some broken or noisy
    task automatic random_image();
        int unsigned w;
        int unsigned h;
        int unsigned n_pix;
        int unsigned ending;
        int unsigned brk_pix;
        int unsigned brk_field;
        int unsigned i;
        bit          huge;
        huge = ($urandom_range(99) < 5);
        w = $urandom_range(1, 3);
        h = $urandom_range(1, 2);
        if ($urandom_range(99) < 8) begin
            if ($urandom_range(1)) begin
                w = 0;
            end else begin
                h = 0;
            end
        end
        // header; a zero dimension is sometimes left empty
        if (huge) begin
            send_num($urandom_range(70000, 999999));
        end else if (w != 0 || $urandom_range(1)) begin
            send_num(w);
        end
        if ($urandom_range(99) < 3) begin
            push_byte(CH_NUL);   // no width
            return;
        end
        push_byte(CH_SPACE);
        if (h != 0 || $urandom_range(1)) begin
            send_num(h);
        end
        if ($urandom_range(99) < 3) begin
            push_byte(CH_NUL);   // no height
            return;
        end
        push_byte(CH_NL);

        n_pix = huge ? $urandom_range(1, 3) : ((w == 0 || h == 0) ? 1 : w * h);
        ending = huge ? 80 : $urandom_range(99);
        brk_pix = $urandom_range(0, n_pix - 1);
        brk_field = $urandom_range(0, 2);

        if (ending >= 94) begin
            // noise after the header, any byte value
            repeat ($urandom_range(3, 10)) push_byte(BYTE_W'($urandom_range(0, 255)));
            push_byte(CH_NUL);
            return;
        end
        for (i = 0; i < n_pix; i++) begin
            if ($urandom_range(99) < 3) begin
                set_origin(pick_origin(), pick_origin());
            end
            if (ending >= 72 && i == brk_pix) begin
                if (ending >= 84) begin
                    // zero inside one of the color fields
                    send_color_field();
                    if (brk_field >= 1) begin
                        push_byte(CH_SPACE);
                        send_color_field();
                    end
                    if (brk_field == 2) begin
                        push_byte(CH_SPACE);
                        send_color_field();
                    end
                end
                push_byte(CH_NUL);
                return;
            end
            send_pixel();
        end
        if ($urandom_range(1)) begin
            repeat ($urandom_range(1, 3)) push_byte(plain_byte());
        end
        push_byte(CH_NUL);
    endtask

    task automatic test_random_images();
        int unsigned target;
        int unsigned images;
        target = bytes_parsed + RANDOM_ITEMS;
        images = 0;
        while (bytes_parsed < target) begin
            calm <= (images >= 8 && images < 16);
            if ($urandom_range(99) < 20) begin
                set_origin(pick_origin(), pick_origin());
            end else if ($urandom_range(99) < 5) begin
                drain_outputs();
            end
            random_image();
            images++;
        end
        calm <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_missing_fields();
        test_full_image();
        test_overflow();
        test_raw_digits();
        test_origin_change();
        test_random_images();

        // wait out every owed item, then let the pipe settle so strays show up
        drain_outputs();
        if (pending_outputs.size() != 0) begin
            $error("%0d output items never arrived", pending_outputs.size());
            mismatches++;
        end

        $display("covered %0d byte items (%0d parsed) over %0d origin writes; %0d pixels checked",
                 bytes_sent, bytes_parsed, origin_writes, kind_count[K_PIXEL]);
        $display("image ends: %0d success, %0d missing field, %0d overflow; %0d mismatches",
                 kind_count[K_SUCCESS],
                 kind_count[K_NOWIDTH] + kind_count[K_NOHEIGHT] + kind_count[K_NORED]
                     + kind_count[K_NOGREEN] + kind_count[K_NOBLUE],
                 kind_count[K_OVERFLOW], mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
